/* rtl/spq_pkg.sv */
// Shared types, constants and helper functions of the quadratic spline evaluator.
// No dependencies; every other file of the block but spq_ram imports this package.
package spq_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int POS_W   = 32;
  localparam int WID_W   = 31;
  localparam int VAL_W   = 48;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W  = 24;
  localparam int WALK_W  = POS_W + SEG_AW + 2;
  localparam int MD_W    = 34;
  localparam int MD_LO_W = MD_W / 2;
  localparam int MA_W    = VAL_W + 3;
  localparam int ADD_W   = VAL_W + 2;
  localparam int PP_W    = MA_W + MD_LO_W + 1;
  localparam int PROD_W  = MA_W + MD_W;
  localparam int QW      = PROD_W - FRAC_W;
  localparam int ENTRY_W = WID_W + 3 * VAL_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_END            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_VALUE          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_HALF_CURVATURE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_CUBIC          = 3'd4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Result region codes.
  localparam logic [1:0] REGION_START = 2'd0;
  localparam logic [1:0] REGION_SEG   = 2'd1;
  localparam logic [1:0] REGION_TAIL  = 2'd2;
  localparam logic [1:0] REGION_END   = 2'd3;

  localparam logic signed [QW-1:0] SAT_MAX = QW'(64'sd140737488355327);
  localparam logic signed [QW-1:0] SAT_MIN = QW'(-64'sd140737488355328);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_WALK, ST_MUL0, ST_MUL1, ST_FIN, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_SEG_T, OP_SEG_VAL, OP_SEG_SLP,
    OP_TL_T, OP_TL_U, OP_TL_VAL, OP_TL_X, OP_TL_SLP, OP_TL_CRV
  } op_t;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [QW-1:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[VAL_W-1:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[VAL_W-1:0];
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic op_t op_next(input op_t op);
    op_t r;
    unique case (op)
      OP_SEG_T:   r = OP_SEG_VAL;
      OP_SEG_VAL: r = OP_SEG_SLP;
      OP_TL_T:    r = OP_TL_U;
      OP_TL_U:    r = OP_TL_VAL;
      OP_TL_VAL:  r = OP_TL_X;
      OP_TL_X:    r = OP_TL_SLP;
      OP_TL_SLP:  r = OP_TL_CRV;
      default:    r = op;
    endcase
    return r;
  endfunction

  function automatic logic op_last(input op_t op);
    return (op == OP_SEG_SLP) || (op == OP_TL_CRV);
  endfunction

endpackage

/* rtl/spq_in_if.sv */
// Request channel of the spline evaluator: valid/ready plus the request payload.
// Depends on spq_pkg for field widths.
interface spq_in_if import spq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [SEG_AW-1:0]        load_index;
  logic [WID_W-1:0]         load_width;
  logic signed [VAL_W-1:0]  load_value;
  logic signed [VAL_W-1:0]  load_slope;
  logic signed [VAL_W-1:0]  load_half_curv;
  logic signed [POS_W-1:0]  position;

  modport source (output valid, req_type, load_index, load_width, load_value,
                  load_slope, load_half_curv, position, input ready);
  modport sink (input valid, req_type, load_index, load_width, load_value,
                load_slope, load_half_curv, position, output ready);
endinterface

/* rtl/spq_out_if.sv */
// Result channel of the spline evaluator: valid/ready plus the result payload.
// Depends on spq_pkg for field widths.
interface spq_out_if import spq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  value;
  logic signed [VAL_W-1:0]  slope;
  logic signed [VAL_W-1:0]  curvature;
  logic [1:0]               region;
  logic [SEG_AW-1:0]        segment_hit;

  modport source (output valid, value, slope, curvature, region, segment_hit,
                  input ready);
  modport sink (input valid, value, slope, curvature, region, segment_hit,
                output ready);
endinterface

/* rtl/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/piecewise_quadratic_spline_eval.sv */
// Top level of the quadratic spline evaluator with a cubic tail.
// Depends on spq_pkg, spq_in_if, spq_out_if and spq_ram.

// A load beat writes one segment into the table RAM and returns an all-zero
// result in the cycle after acceptance. An evaluate beat reads segment 0, then
// walks the segments at one compare-subtract per cycle (one RAM read each),
// and finally runs a short program on one shared 51x18 multiplier: each
// Q24.24 product is formed from two partial products and a shift/saturate/add
// step. A position inside a segment needs three products, the tail six, and a
// position at or outside the ends needs none. The block takes one beat at a
// time and holds the result until it is taken. Table entries have no reset
// value.
module piecewise_quadratic_spline_eval import spq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  spq_in_if.sink               in_ch,
  spq_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [CNT_W-1:0]          seg_count_r;
  logic signed [POS_W-1:0]   tail_end_r;
  logic signed [VAL_W-1:0]   tail_value_r, tail_h_r, tail_c_r;

  logic [CNT_W-1:0]          i_r, n_r;
  logic [1:0]                mode_r;
  logic signed [POS_W-1:0]   pos_r;
  logic signed [WALK_W-1:0]  d_r;
  logic signed [VAL_W-1:0]   h_r, s_r, v_r, t_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]   val_r, slp_r, crv_r;
  logic [1:0]                region_r;
  logic [SEG_AW-1:0]         hit_r;

  logic                      in_acc, ram_we;
  logic [SEG_AW-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;
  logic [WID_W-1:0]          e_w;
  logic signed [VAL_W-1:0]   e_v, e_s, e_h;
  logic                      at_tail, found;

  logic signed [MA_W-1:0]    a_sel, c3, c6;
  logic signed [ADD_W-1:0]   add_sel, tail_h2;
  logic signed [MD_LO_W:0]   m_b;
  logic signed [PP_W-1:0]    pp;
  logic signed [PROD_W-1:0]  pp_ext;
  logic signed [VAL_W-1:0]   q_sat, fin_res;
  logic signed [QW-1:0]      fin_sum;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign ram_we = in_acc && (in_ch.req_type == REQ_LOAD);
  assign ram_wdata = {in_ch.load_half_curv, in_ch.load_slope, in_ch.load_value,
                      in_ch.load_width};

  spq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_tables (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.load_index),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign e_w = ram_rdata[WID_W-1:0];
  assign e_v = ram_rdata[WID_W +: VAL_W];
  assign e_s = ram_rdata[WID_W+VAL_W +: VAL_W];
  assign e_h = ram_rdata[WID_W+2*VAL_W +: VAL_W];

  assign at_tail = (i_r == n_r);
  assign found   = !at_tail && (d_r < $signed({{(WALK_W-WID_W){1'b0}}, e_w}));

  // Operand selection for the shared multiply-add.
  assign c3 = {{3{tail_c_r[VAL_W-1]}}, tail_c_r}
            + {{2{tail_c_r[VAL_W-1]}}, tail_c_r, 1'b0};
  assign c6 = {c3[MA_W-2:0], 1'b0};
  assign tail_h2 = {tail_h_r[VAL_W-1], tail_h_r, 1'b0};

  always_comb begin
    unique case (op_r)
      OP_SEG_T:   a_sel = {{3{h_r[VAL_W-1]}}, h_r};
      OP_SEG_SLP: a_sel = {{2{h_r[VAL_W-1]}}, h_r, 1'b0};
      OP_TL_T:    a_sel = {{3{tail_c_r[VAL_W-1]}}, tail_c_r};
      OP_TL_X:    a_sel = c3;
      OP_TL_CRV:  a_sel = c6;
      default:    a_sel = {{3{t_r[VAL_W-1]}}, t_r};
    endcase
    unique case (op_r)
      OP_SEG_T, OP_SEG_SLP: add_sel = {{2{s_r[VAL_W-1]}}, s_r};
      OP_SEG_VAL:           add_sel = {{2{v_r[VAL_W-1]}}, v_r};
      OP_TL_T:              add_sel = {{2{tail_h_r[VAL_W-1]}}, tail_h_r};
      OP_TL_VAL:            add_sel = {{2{tail_value_r[VAL_W-1]}}, tail_value_r};
      OP_TL_X, OP_TL_CRV:   add_sel = tail_h2;
      default:              add_sel = '0;
    endcase
  end

  // Low half of the position difference is unsigned, high half signed.
  assign m_b = (state_r == ST_MUL0) ? $signed({1'b0, d_r[MD_LO_W-1:0]})
                                    : $signed({d_r[MD_W-1], d_r[MD_W-1:MD_LO_W]});
  assign pp = a_sel * m_b;
  assign pp_ext = {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};

  assign q_sat   = sat48(acc_r[PROD_W-1:FRAC_W]);
  assign fin_sum = {{(QW-ADD_W){add_sel[ADD_W-1]}}, add_sel}
                 + {{(QW-VAL_W){q_sat[VAL_W-1]}}, q_sat};
  assign fin_res = sat48(fin_sum);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.req_type == REQ_EVAL) ? ST_START : ST_DONE;
        end
      end
      ST_START: state_nxt = ST_WALK;
      ST_WALK: begin
        if (mode_r != REGION_SEG) begin
          state_nxt = ST_DONE;
        end else if (found || at_tail) begin
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = op_last(op_r) ? ST_DONE : ST_MUL0;
      ST_DONE: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and RAM address outputs.
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_DONE);
    ram_raddr    = (state_r == ST_WALK) ? SEG_AW'(i_r[SEG_AW-1:0] + SEG_AW'(1)) : '0;
  end

  assign out_ch.value       = val_r;
  assign out_ch.slope       = slp_r;
  assign out_ch.curvature   = crv_r;
  assign out_ch.region      = region_r;
  assign out_ch.segment_hit = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seg_count_r  <= '0;
      tail_end_r   <= POS_W'(32'sd16777216);
      tail_value_r <= '0;
      tail_h_r     <= '0;
      tail_c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEGMENT_COUNT:       seg_count_r  <= cfg_wdata[CNT_W-1:0];
          CFG_TAIL_END:            tail_end_r   <= cfg_wdata[POS_W-1:0];
          CFG_TAIL_VALUE:          tail_value_r <= cfg_wdata[VAL_W-1:0];
          CFG_TAIL_HALF_CURVATURE: tail_h_r     <= cfg_wdata[VAL_W-1:0];
          CFG_TAIL_CUBIC:          tail_c_r     <= cfg_wdata[VAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          val_r    <= '0;
          slp_r    <= '0;
          crv_r    <= '0;
          hit_r    <= '0;
          region_r <= REGION_START;
          pos_r    <= in_ch.position;
          d_r      <= {{(WALK_W-POS_W){in_ch.position[POS_W-1]}}, in_ch.position};
          i_r      <= '0;
          n_r      <= (seg_count_r > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                            : seg_count_r;
          if (in_ch.position <= 0) begin
            mode_r <= REGION_START;
          end else if (in_ch.position >= tail_end_r) begin
            mode_r <= REGION_END;
          end else begin
            mode_r <= REGION_SEG;
          end
        end
      end
      ST_WALK: begin
        if (mode_r == REGION_START) begin
          val_r <= e_v;
        end else if (mode_r == REGION_END) begin
          val_r    <= tail_value_r;
          region_r <= REGION_END;
        end else if (at_tail) begin
          // The difference to the tail end is negative and fits 33 bits.
          d_r <= {{(WALK_W-POS_W){pos_r[POS_W-1]}}, pos_r}
               - {{(WALK_W-POS_W){tail_end_r[POS_W-1]}}, tail_end_r};
          region_r <= REGION_TAIL;
          op_r     <= OP_TL_T;
        end else if (found) begin
          h_r      <= e_h;
          s_r      <= e_s;
          v_r      <= e_v;
          crv_r    <= sat48({{(QW-VAL_W-1){e_h[VAL_W-1]}}, e_h, 1'b0});
          region_r <= REGION_SEG;
          hit_r    <= i_r[SEG_AW-1:0];
          op_r     <= OP_SEG_T;
        end else begin
          d_r <= d_r - $signed({{(WALK_W-WID_W){1'b0}}, e_w});
          i_r <= CNT_W'(i_r + CNT_W'(1));
        end
      end
      ST_MUL0: acc_r <= pp_ext;
      ST_MUL1: acc_r <= acc_r + (pp_ext <<< MD_LO_W);
      ST_FIN: begin
        unique case (op_r)
          OP_SEG_VAL, OP_TL_VAL: val_r <= fin_res;
          OP_SEG_SLP, OP_TL_SLP: slp_r <= fin_res;
          OP_TL_CRV:             crv_r <= fin_res;
          default:               t_r   <= fin_res;
        endcase
        op_r <= op_next(op_r);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request and result side active together");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("new beat taken right after acceptance");

  a_flat_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.region == REGION_START || out_ch.region == REGION_END)
      |-> (out_ch.slope == '0) && (out_ch.curvature == '0) && (out_ch.segment_hit == '0))
    else $error("derivatives nonzero outside the spline range");
`endif

endmodule

/* sim/piecewise_quadratic_spline_eval_tb.sv */
// Self-checking testbench of the quadratic spline evaluator with a cubic tail.
// Depends on spq_pkg, spq_in_if, spq_out_if and the block's RTL under rtl/.
module piecewise_quadratic_spline_eval_tb import spq_pkg::*;;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic                    req_type;
    logic [SEG_AW-1:0]       load_index;
    logic [WID_W-1:0]        load_width;
    logic signed [VAL_W-1:0] load_value;
    logic signed [VAL_W-1:0] load_slope;
    logic signed [VAL_W-1:0] load_half_curv;
    logic signed [POS_W-1:0] position;
  } spline_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] slope;
    logic signed [VAL_W-1:0] curvature;
    logic [1:0]              region;
    logic [SEG_AW-1:0]       segment_hit;
  } spline_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  piecewise_quadratic_spline_eval dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor copy of the tables and registers.
  logic [WID_W-1:0]        mdl_width [MAX_SEGMENTS];
  logic signed [VAL_W-1:0] mdl_value [MAX_SEGMENTS];
  logic signed [VAL_W-1:0] mdl_slope [MAX_SEGMENTS];
  logic signed [VAL_W-1:0] mdl_curv  [MAX_SEGMENTS];
  int unsigned             seg_in_use = 0;
  logic signed [POS_W-1:0] end_pos = 32'sd16777216;
  logic signed [VAL_W-1:0] end_value = '0;
  logic signed [VAL_W-1:0] end_half_curv = '0;
  logic signed [VAL_W-1:0] end_cubic = '0;

  // Generator-side view of what has been loaded, used to keep reads legal.
  bit                      gen_loaded [MAX_SEGMENTS];
  logic [WID_W-1:0]        gen_width  [MAX_SEGMENTS];

  spline_req_t pending_reqs[$];
  spline_res_t expected_results[$];

  int send_idle = 36;
  int recv_idle = 49;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int checked = 0;
  int region_hits [4] = '{0, 0, 0, 0};
  int loads_done = 0;
  longint cycles = 0;

  function automatic logic signed [VAL_W-1:0] clamp48(input logic signed [127:0] x);
    if (x > 128'sd140737488355327) return 48'sh7FFFFFFFFFFF;
    if (x < -128'sd140737488355328) return 48'sh800000000000;
    return x[VAL_W-1:0];
  endfunction

  // Q24.24 times Q8.24, floored and saturated.
  function automatic logic signed [127:0] fxmul(input logic signed [127:0] a,
                                                input logic signed [127:0] d);
    logic signed [127:0] p;
    p = a * d;
    return clamp48(p >>> FRAC_W);
  endfunction

  function automatic spline_res_t spline_eval(input logic signed [POS_W-1:0] pos);
    spline_res_t r;
    logic signed [127:0] p, d, w, h2, t, u, e;
    int n;
    bit found;
    r = '{default: '0};
    p = pos;
    found = 1'b0;
    if (p <= 0) begin
      r.region = REGION_START;
      r.value = mdl_value[0];
    end else if (p >= end_pos) begin
      r.region = REGION_END;
      r.value = end_value;
    end else begin
      n = (seg_in_use < MAX_SEGMENTS) ? seg_in_use : MAX_SEGMENTS;
      d = p;
      for (int i = 0; i < n && !found; i++) begin
        w = $signed({97'd0, mdl_width[i]});
        if (d < w) begin
          h2 = 2 * 128'(mdl_curv[i]);
          t = clamp48(128'(mdl_slope[i]) + fxmul(128'(mdl_curv[i]), d));
          r.value = clamp48(128'(mdl_value[i]) + fxmul(t, d));
          r.slope = clamp48(128'(mdl_slope[i]) + fxmul(h2, d));
          r.curvature = clamp48(h2);
          r.region = REGION_SEG;
          r.segment_hit = i[SEG_AW-1:0];
          found = 1'b1;
        end else begin
          d = d - w;
        end
      end
      if (!found) begin
        e = p - 128'(end_pos);
        t = clamp48(128'(end_half_curv) + fxmul(128'(end_cubic), e));
        u = fxmul(t, e);
        h2 = 2 * 128'(end_half_curv);
        r.value = clamp48(128'(end_value) + fxmul(u, e));
        r.slope = clamp48(fxmul(clamp48(h2 + fxmul(3 * 128'(end_cubic), e)), e));
        r.curvature = clamp48(h2 + fxmul(6 * 128'(end_cubic), e));
        r.region = REGION_TAIL;
      end
    end
    return r;
  endfunction

  // Input driver.
  spline_req_t drv_req;
  spline_res_t drv_res;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        drv_res = '{default: '0};
        if (in_ch.req_type == REQ_LOAD) begin
          mdl_width[in_ch.load_index] = in_ch.load_width;
          mdl_value[in_ch.load_index] = in_ch.load_value;
          mdl_slope[in_ch.load_index] = in_ch.load_slope;
          mdl_curv[in_ch.load_index]  = in_ch.load_half_curv;
          loads_done++;
        end else begin
          drv_res = spline_eval(in_ch.position);
          region_hits[drv_res.region]++;
        end
        expected_results.push_back(drv_res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          drv_req = pending_reqs.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.req_type       <= drv_req.req_type;
          in_ch.load_index     <= drv_req.load_index;
          in_ch.load_width     <= drv_req.load_width;
          in_ch.load_value     <= drv_req.load_value;
          in_ch.load_slope     <= drv_req.load_slope;
          in_ch.load_half_curv <= drv_req.load_half_curv;
          in_ch.position       <= drv_req.position;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker; a hold request stalls it for a long stretch.
  spline_res_t mon_exp;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat: value %0d", out_ch.value);
        end else begin
          mon_exp = expected_results.pop_front();
          checked++;
          if (out_ch.value !== mon_exp.value || out_ch.slope !== mon_exp.slope ||
              out_ch.curvature !== mon_exp.curvature || out_ch.region !== mon_exp.region ||
              out_ch.segment_hit !== mon_exp.segment_hit) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch on result %0d:", checked);
              $display("  expected val %0d slp %0d crv %0d region %0d seg %0d",
                       mon_exp.value, mon_exp.slope, mon_exp.curvature,
                       mon_exp.region, mon_exp.segment_hit);
              $display("  actual   val %0d slp %0d crv %0d region %0d seg %0d",
                       out_ch.value, out_ch.slope, out_ch.curvature,
                       out_ch.region, out_ch.segment_hit);
            end
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return 48'h7FFFFFFFFFFF;
      1: return 48'h800000000000;
      2: return $signed(r[47:0]) >>> $urandom_range(47);
      default: return $signed(r[47:0]) >>> $urandom_range(30, 10);
    endcase
  endfunction

  task automatic push_load(input int idx, input logic [WID_W-1:0] w,
                           input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] s,
                           input logic [VAL_W-1:0] h);
    spline_req_t r;
    r.req_type = REQ_LOAD;
    r.load_index = idx[SEG_AW-1:0];
    r.load_width = w;
    r.load_value = v;
    r.load_slope = s;
    r.load_half_curv = h;
    r.position = POS_W'($urandom);
    gen_loaded[idx] = 1'b1;
    gen_width[idx] = w;
    pending_reqs.push_back(r);
  endtask

  task automatic push_eval(input logic signed [POS_W-1:0] pos);
    spline_req_t r;
    r.req_type = REQ_EVAL;
    r.load_index = SEG_AW'($urandom);
    r.load_width = WID_W'($urandom);
    r.load_value = rand48();
    r.load_slope = rand48();
    r.load_half_curv = rand48();
    r.position = pos;
    // Position zero and below reads entry 0, which must have been loaded.
    if (!gen_loaded[0] && pos <= 0) r.position = 32'sd1;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [WID_W-1:0] rand_width();
    case ($urandom_range(19))
      0: return '0;
      1: return 31'h7FFFFFFF;
      2: return WID_W'($urandom);
      default: return WID_W'($urandom_range(32'h0300_0000));
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    longint span;
    span = longint'(end_pos) - 1;
    case ($urandom_range(19))
      0: return -32'sd2147483648;
      1: return 32'sd2147483647;
      2: return 32'sd0;
      3: return end_pos;
      4: return -$signed(32'($urandom_range(32'h0400_0000)));
      5, 6: return $urandom;
      default: begin
        if (span < 1) return $urandom;
        return 32'(1 + ({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SEGMENT_COUNT:       seg_in_use = data[CNT_W-1:0];
      CFG_TAIL_END:            end_pos = data[POS_W-1:0];
      CFG_TAIL_VALUE:          end_value = data[VAL_W-1:0];
      CFG_TAIL_HALF_CURVATURE: end_half_curv = data[VAL_W-1:0];
      CFG_TAIL_CUBIC:          end_cubic = data[VAL_W-1:0];
      default: ;
    endcase
  endtask

  // Picks a legal segment count, a tail end (mostly near the end of the segments) and random tail coefficients.
  task automatic random_config(input int ph);
    int prefix, cnt;
    longint sum;
    prefix = 0;
    while (prefix < MAX_SEGMENTS && gen_loaded[prefix]) prefix++;
    case (ph % 3)
      0: cnt = prefix;
      1: cnt = $urandom_range(prefix);
      default: cnt = (prefix < 8) ? prefix : $urandom_range(8);
    endcase
    sum = 0;
    for (int i = 0; i < cnt; i++) sum += gen_width[i];
    sum += $urandom_range(32'h0400_0000);
    if (sum > 64'd2147483647) sum = 2147483647;
    write_reg(CFG_SEGMENT_COUNT, CFG_W'(cnt));
    case ($urandom_range(9))
      0: write_reg(CFG_TAIL_END, 48'(-32'sd2147483648));
      1: write_reg(CFG_TAIL_END, 48'(32'sd2147483647));
      2: write_reg(CFG_TAIL_END, 48'(-$signed(32'($urandom_range(32'h0100_0000)))));
      default: write_reg(CFG_TAIL_END, 48'(sum));
    endcase
    write_reg(CFG_TAIL_VALUE, rand48());
    write_reg(CFG_TAIL_HALF_CURVATURE, rand48());
    write_reg(CFG_TAIL_CUBIC, rand48());
  endtask

  task automatic random_items(input int count, input int load_pct);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < load_pct)
        push_load($urandom_range(MAX_SEGMENTS - 1), rand_width(), rand48(), rand48(), rand48());
      else
        push_eval(rand_pos());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LOAD;
    in_ch.load_index = '0;
    in_ch.load_width = '0;
    in_ch.load_value = '0;
    in_ch.load_slope = '0;
    in_ch.load_half_curv = '0;
    in_ch.position = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      gen_loaded[i] = 1'b0;
      gen_width[i] = '0;
      mdl_width[i] = '0;
      mdl_value[i] = '0;
      mdl_slope[i] = '0;
      mdl_curv[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings first: no segments, tail up to 1.0.
    push_load(0, 31'h0080_0000, 48'h7FFFFFFFFFFF, 48'h800000000000, 48'h7FFFFFFFFFFF);
    push_eval(32'sd0);
    push_eval(-32'sd2147483648);
    push_eval(32'sd8388608);
    push_eval(32'sd16777216);
    push_eval(32'sd2147483647);
    push_load(63, 31'h7FFFFFFF, 48'h800000000000, 48'h7FFFFFFFFFFF, 48'h800000000000);
    push_load(1, 31'h0100_0000, 48'h000001000000, 48'h000000800000, 48'hFFFFFF000000);
    // A zero-width segment is skipped by the walk.
    push_load(2, 31'h0, 48'h123456789ABC, 48'h0, 48'h0);
    push_load(3, 31'h0200_0000, 48'hFFFF00000000, 48'h000100000000, 48'h000080000000);
    wait_idle();
    write_reg(CFG_SEGMENT_COUNT, CFG_W'(4));
    write_reg(CFG_TAIL_END, 48'h0000_0500_0000);
    write_reg(CFG_TAIL_VALUE, 48'h000002000000);
    write_reg(CFG_TAIL_HALF_CURVATURE, 48'h7FFFFFFFFFFF);
    write_reg(CFG_TAIL_CUBIC, 48'h800000000000);
    push_eval(32'sd4194304);
    push_eval(32'sd8388608);
    push_eval(32'sd16777216);
    push_eval(32'sd25165824);
    push_eval(32'sd50331648);
    push_eval(32'sd67108863);
    push_eval(32'sd83886080);
    push_eval(32'sd83886079);
    // Tail end at or below zero.
    wait_idle();
    write_reg(CFG_TAIL_END, 48'(-32'sd16777216));
    push_eval(32'sd0);
    push_eval(32'sd1);
    push_eval(-32'sd1);
    wait_idle();

    // Fill the tables so long walks become legal.
    send_idle = 36;
    recv_idle = 49;
    for (int i = 0; i < MAX_SEGMENTS; i++)
      if ($urandom_range(9) != 0 || i < 32)
        push_load(i, rand_width(), rand48(), rand48(), rand48());
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 36 : (ph < 4) ? 49 : 0;
      recv_idle = (ph < 2) ? 49 : (ph < 4) ? 36 : 0;
      random_config(ph);
      random_items(120, 25);
      if (ph == 2) begin
        hold_req = ~hold_req;
        random_items(40, 10);
      end
      // Sender pauses here until every outstanding result has come back.
      wait_idle();
      random_items(120, 25);
      wait_idle();
    end
    // Widest setting: every segment in use, walk ends at the largest position.
    for (int i = 0; i < MAX_SEGMENTS; i++)
      if (!gen_loaded[i]) push_load(i, rand_width(), rand48(), rand48(), rand48());
    wait_idle();
    write_reg(CFG_SEGMENT_COUNT, CFG_W'(MAX_SEGMENTS));
    write_reg(CFG_TAIL_END, 48'(32'sd2147483647));
    random_items(60, 10);
    wait_idle();
    write_reg(CFG_SEGMENT_COUNT, CFG_W'(0));
    random_items(20, 20);
    wait_idle();
    repeat (100) @(posedge clk);

    $display("Checked %0d results from %0d loads; evaluates by region start/seg/tail/end:",
             checked, loads_done);
    $display("  %0d / %0d / %0d / %0d, with %0d mismatches", region_hits[0], region_hits[1],
             region_hits[2], region_hits[3], errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_ram.sv
rtl/piecewise_quadratic_spline_eval.sv
sim/piecewise_quadratic_spline_eval_tb.sv
